// ===== rtl/rbf_pkg.sv =====
// ----------------------------------------------------------------------------
// rbf_pkg
// shared types and constants for the ring buffer fifo
// ----------------------------------------------------------------------------
package rbf_pkg;

  localparam int DATA_W   = 32;   // push_data / pop_data width
  localparam int CAP_W    = 7;    // capacity register and occupancy width
  localparam int CNT_W    = 32;   // wrapping event counters
  localparam int CMP_W    = 16;   // common width for index and fill compares
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // operation carried on the input request
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  // result status code
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // controller to datapath commands, valid for one cycle
  typedef struct packed {
    logic accept;    // a request is taken this cycle
    logic push;      // store item
    logic refuse;    // push into a full queue
    logic pop;       // read item
    logic underrun;  // pop from an empty queue
    logic clear;     // clear indices, fill level and counters
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic full;
    logic empty;
  } stat_t;

endpackage

// ===== rtl/rbf_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbf_ctrl
// request sequencing and output handshake for the ring buffer fifo
// ----------------------------------------------------------------------------
module rbf_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [rbf_pkg::MODE_W-1:0]    in_mode,
  input  rbf_pkg::stat_t                stat,
  output rbf_pkg::cmd_t                 cmd,
  output logic                          out_tvalid,
  input  logic                          out_tready
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  // decode the accepted request
  always_comb begin
    cmd        = '0;
    cmd.accept = accept;
    if (accept) begin
      unique case (rbf_pkg::mode_t'(in_mode))
        rbf_pkg::MODE_PUSH: begin
          cmd.push   = !stat.full;
          cmd.refuse = stat.full;
        end
        rbf_pkg::MODE_POP: begin
          cmd.pop      = !stat.empty;
          cmd.underrun = stat.empty;
        end
        rbf_pkg::MODE_CLEAR: begin
          cmd.clear = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    unique case (state_r)
      S_IDLE: begin
        if (out_valid_r && out_tready) begin
          out_valid_nxt = 1'b0;
        end
        if (accept) begin
          if (cmd.pop) begin
            // wait in S_READ for the registered slot read
            state_nxt = S_READ;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_READ: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/rbf_datapath.sv =====
// ----------------------------------------------------------------------------
// rbf_datapath
// slot memory, indices, fill level and event counters
// ----------------------------------------------------------------------------
module rbf_datapath #(
  parameter int DEPTH      = 64,
  parameter int ITEM_BYTES = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [rbf_pkg::CAP_W-1:0]       cfg_wr_data,
  input  rbf_pkg::cmd_t                   cmd,
  input  logic [rbf_pkg::DATA_W-1:0]      push_data,
  output rbf_pkg::stat_t                  stat,
  output logic [rbf_pkg::STATUS_W-1:0]    res_status,
  output logic [rbf_pkg::DATA_W-1:0]      res_pop_data,
  output logic [rbf_pkg::CAP_W-1:0]       res_occupancy,
  output logic [rbf_pkg::CNT_W-1:0]       res_overflow_total,
  output logic [rbf_pkg::CNT_W-1:0]       res_push_total,
  output logic [rbf_pkg::CNT_W-1:0]       res_pop_total
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MEM_W = (ITEM_BYTES >= 4) ? rbf_pkg::DATA_W : ITEM_BYTES * 8;
  localparam int CMP_W = rbf_pkg::CMP_W;

  logic [MEM_W-1:0] mem [DEPTH];
  logic [MEM_W-1:0] rd_data_r;
  logic             pop_flag_r;
  logic [rbf_pkg::STATUS_W-1:0] status_r;

  logic [rbf_pkg::CAP_W-1:0] cap_r;
  logic [IDX_W-1:0]          wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0]          rd_idx_r, rd_idx_nxt;
  logic [rbf_pkg::CAP_W-1:0] fill_r;
  logic [rbf_pkg::CNT_W-1:0] ovf_cnt_r, push_cnt_r, pop_cnt_r;

  logic [CMP_W-1:0] cap_ext, eff_cap, wr_inc, rd_inc;
  logic             clr;

  // capacity clamped to 1..DEPTH
  assign cap_ext = CMP_W'(cap_r);
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(DEPTH)) begin
      eff_cap = CMP_W'(DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign wr_inc     = CMP_W'(wr_idx_r) + CMP_W'(1);
  assign rd_inc     = CMP_W'(rd_idx_r) + CMP_W'(1);
  assign wr_idx_nxt = (wr_inc >= eff_cap) ? '0 : wr_inc[IDX_W-1:0];
  assign rd_idx_nxt = (rd_inc >= eff_cap) ? '0 : rd_inc[IDX_W-1:0];

  assign stat.full  = (CMP_W'(fill_r) >= eff_cap);
  assign stat.empty = (fill_r == '0);

  assign clr = cfg_wr_en || cmd.clear;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r      <= rbf_pkg::CAP_RESET;
      wr_idx_r   <= '0;
      rd_idx_r   <= '0;
      fill_r     <= '0;
      ovf_cnt_r  <= '0;
      push_cnt_r <= '0;
      pop_cnt_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (clr) begin
        wr_idx_r   <= '0;
        rd_idx_r   <= '0;
        fill_r     <= '0;
        ovf_cnt_r  <= '0;
        push_cnt_r <= '0;
        pop_cnt_r  <= '0;
      end else begin
        if (cmd.push) begin
          wr_idx_r   <= wr_idx_nxt;
          fill_r     <= fill_r + 1'b1;
          push_cnt_r <= push_cnt_r + 1'b1;
        end
        if (cmd.refuse) begin
          ovf_cnt_r <= ovf_cnt_r + 1'b1;
        end
        if (cmd.pop) begin
          rd_idx_r  <= rd_idx_nxt;
          fill_r    <= fill_r - 1'b1;
          pop_cnt_r <= pop_cnt_r + 1'b1;
        end
      end
    end
  end

  // slot memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_idx_r] <= push_data[MEM_W-1:0];
    end
    if (cmd.pop) begin
      rd_data_r <= mem[rd_idx_r];
    end
  end

  // result status held until the next request
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pop_flag_r <= cmd.pop;
      if (cmd.refuse) begin
        status_r <= rbf_pkg::ST_FULL;
      end else if (cmd.underrun) begin
        status_r <= rbf_pkg::ST_EMPTY;
      end else begin
        status_r <= rbf_pkg::ST_OK;
      end
    end
  end

  assign res_status         = status_r;
  assign res_pop_data       = pop_flag_r ? rbf_pkg::DATA_W'(rd_data_r) : '0;
  assign res_occupancy      = fill_r;
  assign res_overflow_total = ovf_cnt_r;
  assign res_push_total     = push_cnt_r;
  assign res_pop_total      = pop_cnt_r;

endmodule

// ===== rtl/ring_buffer_fifo.sv =====
// ----------------------------------------------------------------------------
// ring_buffer_fifo
// timing: push, clear and no-op results are valid the cycle after the request; a
//   successful pop waits in S_READ for the registered read of the slot memory
// throughput: 1 request per cycle while out_tready is high; pops stall in S_READ
// reset: synchronous; indices, fill level and counters clear, capacity 64
// ----------------------------------------------------------------------------
module ring_buffer_fifo #(
  parameter int DEPTH      = 64,   // built number of slots
  parameter int ITEM_BYTES = 4     // stored bytes per item, at most 4
) (
  input  logic         clk,
  input  logic         rst_n,

  // configuration: capacity register, write clears queue state
  input  logic         cfg_wr_en,
  input  logic [6:0]   cfg_wr_data,

  // request channel
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // [31:0] push_data
  input  logic [1:0]   in_tuser,   // [1:0] mode

  // result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // [31:0] pop_data, [38:32] occupancy,
                                   // [70:39] overflow_total, [102:71] push_total,
                                   // [134:103] pop_total, [135] zero
  output logic [1:0]   out_tuser   // [1:0] status
);

  rbf_pkg::cmd_t  cmd;
  rbf_pkg::stat_t stat;

  logic [rbf_pkg::DATA_W-1:0] pop_data;
  logic [rbf_pkg::CAP_W-1:0]  occupancy;
  logic [rbf_pkg::CNT_W-1:0]  overflow_total, push_total, pop_total;

  // controller: accepts a request, issues commands, runs the output handshake
  rbf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_mode    (in_tuser),
    .stat       (stat),
    .cmd        (cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  // datapath: slots, wrapping indices, fill level, counters
  rbf_datapath #(
    .DEPTH      (DEPTH),
    .ITEM_BYTES (ITEM_BYTES)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .cmd                (cmd),
    .push_data          (in_tdata),
    .stat               (stat),
    .res_status         (out_tuser),
    .res_pop_data       (pop_data),
    .res_occupancy      (occupancy),
    .res_overflow_total (overflow_total),
    .res_push_total     (push_total),
    .res_pop_total      (pop_total)
  );

  // occupancy and counters are read live: no new request is taken while a
  // result waits, so they still hold the post-request values
  assign out_tdata = {1'b0, pop_total, push_total, overflow_total, occupancy, pop_data};

  // queue never holds more than the built depth
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(occupancy) <= DEPTH))
    else $error("occupancy above depth");

  // an empty-pop result returns no data
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == rbf_pkg::ST_EMPTY)) |-> (pop_data == '0))
    else $error("data on empty pop");

  // a request that is not a successful pop has its result next cycle
  a_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && !cmd.pop) |=> out_tvalid)
    else $error("missing result after request");

  // no request taken while a result is stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid && !out_tready))
    else $error("request taken over stalled result");

endmodule
